// ----- rtl/tun_pkg.sv -----
`timescale 1ns / 1ps

package tun_pkg;

   localparam int IN_W    = 16;   // Q8.8 vertex coordinate
   localparam int EDGE_W  = 17;   // exact edge difference
   localparam int CROSS_W = 34;   // exact cross product, signed
   localparam int MAG_W   = 33;   // magnitude of a cross component
   localparam int POS_W   = 6;    // leading-one position over MAG_W bits
   localparam int NORM_W  = 31;   // normalized magnitude, top bit at 30
   localparam int SQ_W    = 62;   // square of a normalized magnitude
   localparam int SUM_W   = 64;   // sum of three squares
   localparam int ROOT_W  = 32;   // integer square root
   localparam int FRAC_W  = 14;   // Q1.14 fraction bits
   localparam int NUM_W   = NORM_W + FRAC_W + 1;  // dividend with rounding term
   localparam int Q_W     = 15;   // quotient, at most 16384
   localparam int OUT_W   = 16;

   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = Q_W;

   // carried alongside the square root
   typedef struct packed {
      logic                           degen;
      logic [2:0]                     neg;
      logic [2:0][NORM_W-1:0]         mag;
   } tun_sqrt_side_type;

   // carried alongside the divider
   typedef struct packed {
      logic       degen;
      logic [2:0] neg;
   } tun_div_side_type;

endpackage

// ----- rtl/tun_if.sv -----
`timescale 1ns / 1ps

interface tun_req_if;
   logic        valid;
   logic        ready;
   logic signed [tun_pkg::IN_W-1:0] v0_x;
   logic signed [tun_pkg::IN_W-1:0] v0_y;
   logic signed [tun_pkg::IN_W-1:0] v0_z;
   logic signed [tun_pkg::IN_W-1:0] v1_x;
   logic signed [tun_pkg::IN_W-1:0] v1_y;
   logic signed [tun_pkg::IN_W-1:0] v1_z;
   logic signed [tun_pkg::IN_W-1:0] v2_x;
   logic signed [tun_pkg::IN_W-1:0] v2_y;
   logic signed [tun_pkg::IN_W-1:0] v2_z;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   input ready);
   modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   output ready);
endinterface

interface tun_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [tun_pkg::OUT_W-1:0] normal_x;
   logic signed [tun_pkg::OUT_W-1:0] normal_y;
   logic signed [tun_pkg::OUT_W-1:0] normal_z;
   logic        degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- rtl/tun_sqrt.sv -----
`timescale 1ns / 1ps

// Pipelined restoring square root, one root bit per stage.
module tun_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [tun_pkg::SUM_W-1:0]          in_sum,
   input  tun_pkg::tun_sqrt_side_type         in_side,
   output logic                               out_valid,
   output logic [tun_pkg::ROOT_W-1:0]         out_root,
   output tun_pkg::tun_sqrt_side_type         out_side
);

   localparam int N     = tun_pkg::SQRT_STAGES;
   localparam int REM_W = tun_pkg::ROOT_W + 1;
   localparam int CUR_W = REM_W + 2;

   logic [REM_W-1:0]                rem_ff   [N];
   logic [tun_pkg::ROOT_W-1:0]      root_ff  [N];
   logic [tun_pkg::SUM_W-1:0]       sum_ff   [N];
   tun_pkg::tun_sqrt_side_type      side_ff  [N];
   logic [N-1:0]                    valid_ff;

   logic [REM_W-1:0]                rem_src  [N];
   logic [tun_pkg::ROOT_W-1:0]      root_src [N];
   logic [tun_pkg::SUM_W-1:0]       sum_src  [N];
   logic [CUR_W-1:0]                cur      [N];
   logic [CUR_W-1:0]                trial    [N];
   logic [N-1:0]                    ge;
   logic [REM_W-1:0]                rem_in   [N];
   logic [tun_pkg::ROOT_W-1:0]      root_in  [N];

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      sum_src[0]  = in_sum;
      for (int j = 1; j < N; j++) begin
         rem_src[j]  = rem_ff[j-1];
         root_src[j] = root_ff[j-1];
         sum_src[j]  = sum_ff[j-1];
      end
      for (int j = 0; j < N; j++) begin
         cur[j]   = {rem_src[j], sum_src[j][tun_pkg::SUM_W-1 -: 2]};
         trial[j] = {1'b0, root_src[j], 2'b01};
         ge[j]    = (cur[j] >= trial[j]);
         // remainder stays within 2*root, so it fits REM_W
         rem_in[j]  = ge[j] ? REM_W'(cur[j] - trial[j]) : cur[j][REM_W-1:0];
         root_in[j] = {root_src[j][tun_pkg::ROOT_W-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
      if (en) begin
         for (int j = 0; j < N; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            sum_ff[j]  <= sum_src[j] << 2;
            side_ff[j] <= (j == 0) ? in_side : side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ----- rtl/tun_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, three lanes sharing one divisor,
// one quotient bit per stage.
module tun_div (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  logic [tun_pkg::ROOT_W-1:0]                  in_divisor,
   input  logic [2:0][tun_pkg::NUM_W-1:0]              in_num,
   input  tun_pkg::tun_div_side_type                   in_side,
   output logic                                        out_valid,
   output logic [2:0][tun_pkg::Q_W-1:0]                out_quot,
   output tun_pkg::tun_div_side_type                   out_side
);

   localparam int N     = tun_pkg::DIV_STAGES;
   localparam int D_W   = tun_pkg::ROOT_W;
   localparam int QW    = tun_pkg::Q_W;
   localparam int HI_W  = tun_pkg::NUM_W - QW;

   logic [2:0][D_W-1:0]         rem_ff   [N];
   logic [2:0][QW-1:0]          low_ff   [N];
   logic [2:0][QW-1:0]          quot_ff  [N];
   logic [D_W-1:0]              dvs_ff   [N];
   tun_pkg::tun_div_side_type   side_ff  [N];
   logic [N-1:0]                valid_ff;

   logic [2:0][D_W-1:0]         rem_src  [N];
   logic [2:0][QW-1:0]          low_src  [N];
   logic [2:0][QW-1:0]          quot_src [N];
   logic [D_W-1:0]              dvs_src  [N];
   tun_pkg::tun_div_side_type   side_src [N];
   logic [2:0][D_W:0]           cur      [N];
   logic [2:0][D_W-1:0]         rem_in   [N];
   logic [2:0][QW-1:0]          quot_in  [N];
   logic                        ge;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // quotient fits QW bits, so the high part is already below the divisor
         rem_src[0][k]  = D_W'(in_num[k][tun_pkg::NUM_W-1 -: HI_W]);
         low_src[0][k]  = in_num[k][QW-1:0];
         quot_src[0][k] = '0;
      end
      dvs_src[0]  = in_divisor;
      side_src[0] = in_side;
      for (int j = 1; j < N; j++) begin
         rem_src[j]  = rem_ff[j-1];
         low_src[j]  = low_ff[j-1];
         quot_src[j] = quot_ff[j-1];
         dvs_src[j]  = dvs_ff[j-1];
         side_src[j] = side_ff[j-1];
      end
      ge = 1'b0;
      for (int j = 0; j < N; j++) begin
         for (int k = 0; k < 3; k++) begin
            cur[j][k]     = {rem_src[j][k], low_src[j][k][QW-1]};
            ge            = (cur[j][k] >= {1'b0, dvs_src[j]});
            rem_in[j][k]  = ge ? D_W'(cur[j][k] - {1'b0, dvs_src[j]}) : cur[j][k][D_W-1:0];
            quot_in[j][k] = {quot_src[j][k][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
      if (en) begin
         for (int j = 0; j < N; j++) begin
            rem_ff[j]  <= rem_in[j];
            quot_ff[j] <= quot_in[j];
            dvs_ff[j]  <= dvs_src[j];
            side_ff[j] <= side_src[j];
            for (int k = 0; k < 3; k++) begin
               low_ff[j][k] <= low_src[j][k] << 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quot  = quot_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ----- rtl/triangle_unit_normal_top.sv -----
`timescale 1ns / 1ps

// Unit face normal of one triangle per item. Vertices come in as signed Q8.8;
// the normal is (v2 - v0) x (v1 - v0) scaled to unit length, in signed Q1.14,
// rounded half away from zero. A zero cross product gives a zero normal with
// degenerate set. Fully pipelined, one item per clock while not stalled, with
// 8 front stages, 32 square-root stages, 1 dividend stage, 15 divider stages and
// 1 output register. The whole pipe advances whenever the output register is
// empty or being taken, so req_ch.ready drops exactly while a result waits in
// the output register and rsp_ch.ready is low; nothing is lost or repeated on
// a stall.
module triangle_unit_normal_top (
   input  logic      clock,
   input  logic      reset,
   tun_req_if.sink   req_ch,
   tun_rsp_if.source rsp_ch
);

   localparam int EW = tun_pkg::EDGE_W;
   localparam int CW = tun_pkg::CROSS_W;
   localparam int MW = tun_pkg::MAG_W;
   localparam int NW = tun_pkg::NORM_W;

   logic en;

   // stage 1: edges
   logic                           s1_vld_ff;
   logic signed [2:0][EW-1:0]      e1_ff, e2_ff;
   // stage 2: partial products of the cross product
   logic                           s2_vld_ff;
   logic signed [2:0][CW-1:0]      pa_ff, pb_ff;
   // stage 3: cross product
   logic                           s3_vld_ff;
   logic signed [2:0][CW-1:0]      c_ff;
   // stage 4: sign and magnitude
   logic                           s4_vld_ff;
   logic [2:0]                     s4_neg_ff;
   logic [2:0][MW-1:0]             s4_mag_ff;
   // stage 5: leading-one position
   logic                           s5_vld_ff;
   logic [2:0]                     s5_neg_ff;
   logic [2:0][MW-1:0]             s5_mag_ff;
   logic [tun_pkg::POS_W-1:0]      s5_pos_ff;
   logic                           s5_degen_ff;
   // stage 6: normalized magnitudes
   logic                           s6_vld_ff;
   tun_pkg::tun_sqrt_side_type     s6_side_ff;
   // stage 7: squares
   logic                           s7_vld_ff;
   tun_pkg::tun_sqrt_side_type     s7_side_ff;
   logic [2:0][tun_pkg::SQ_W-1:0]  s7_sq_ff;
   // stage 8: sum of squares
   logic                           s8_vld_ff;
   tun_pkg::tun_sqrt_side_type     s8_side_ff;
   logic [tun_pkg::SUM_W-1:0]      s8_sum_ff;

   logic                           sq_vld;
   logic [tun_pkg::ROOT_W-1:0]     sq_root;
   tun_pkg::tun_sqrt_side_type     sq_side;

   // dividend stage
   logic                                  s9_vld_ff;
   logic [tun_pkg::ROOT_W-1:0]            s9_len_ff;
   logic [2:0][tun_pkg::NUM_W-1:0]        s9_num_ff;
   tun_pkg::tun_div_side_type             s9_side_ff;

   logic                                  dv_vld;
   logic [2:0][tun_pkg::Q_W-1:0]          dv_quot;
   tun_pkg::tun_div_side_type             dv_side;

   // output register
   logic                                  out_vld_ff;
   logic signed [2:0][tun_pkg::OUT_W-1:0] out_n_ff;
   logic                                  out_degen_ff;

   logic signed [2:0][EW-1:0]      e1_in, e2_in;
   logic [MW-1:0]                  mag_or;
   logic [tun_pkg::POS_W-1:0]      pos_in;
   logic [2:0][NW-1:0]             norm_in;
   logic [MW+NW-2:0]               wide;
   logic [2:0][tun_pkg::NUM_W-1:0] num_in;
   logic signed [2:0][tun_pkg::OUT_W-1:0] n_in;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      e1_in[0] = EW'(req_ch.v2_x) - EW'(req_ch.v0_x);
      e1_in[1] = EW'(req_ch.v2_y) - EW'(req_ch.v0_y);
      e1_in[2] = EW'(req_ch.v2_z) - EW'(req_ch.v0_z);
      e2_in[0] = EW'(req_ch.v1_x) - EW'(req_ch.v0_x);
      e2_in[1] = EW'(req_ch.v1_y) - EW'(req_ch.v0_y);
      e2_in[2] = EW'(req_ch.v1_z) - EW'(req_ch.v0_z);
   end

   // leading one of the OR of the magnitudes is the leading one of the largest
   always_comb begin
      mag_or = s4_mag_ff[0] | s4_mag_ff[1] | s4_mag_ff[2];
      pos_in = '0;
      for (int b = 0; b < MW; b++) begin
         if (mag_or[b]) begin
            pos_in = tun_pkg::POS_W'(b);
         end
      end
   end

   // shift so the largest lands at bit NW-1; right shifts truncate
   always_comb begin
      wide = '0;
      for (int k = 0; k < 3; k++) begin
         wide       = {s5_mag_ff[k], {(NW-1){1'b0}}} >> s5_pos_ff;
         norm_in[k] = wide[NW-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = {1'b0, sq_side.mag[k], {tun_pkg::FRAC_W{1'b0}}}
                   + tun_pkg::NUM_W'(sq_root >> 1);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_side.degen) begin
            n_in[k] = '0;
         end else if (dv_side.neg[k]) begin
            n_in[k] = -tun_pkg::OUT_W'(dv_quot[k]);
         end else begin
            n_in[k] = tun_pkg::OUT_W'(dv_quot[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_ch.valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= sq_vld;
         out_vld_ff <= dv_vld;
      end
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;

         // c = e1 x e2; elements of a packed array select as unsigned
         pa_ff[0] <= CW'($signed(e1_ff[1]) * $signed(e2_ff[2]));
         pb_ff[0] <= CW'($signed(e1_ff[2]) * $signed(e2_ff[1]));
         pa_ff[1] <= CW'($signed(e1_ff[2]) * $signed(e2_ff[0]));
         pb_ff[1] <= CW'($signed(e1_ff[0]) * $signed(e2_ff[2]));
         pa_ff[2] <= CW'($signed(e1_ff[0]) * $signed(e2_ff[1]));
         pb_ff[2] <= CW'($signed(e1_ff[1]) * $signed(e2_ff[0]));

         for (int k = 0; k < 3; k++) begin
            c_ff[k]      <= pa_ff[k] - pb_ff[k];
            s4_neg_ff[k] <= c_ff[k][CW-1];
            s4_mag_ff[k] <= c_ff[k][CW-1] ? MW'(-c_ff[k]) : MW'(c_ff[k]);
         end

         s5_neg_ff   <= s4_neg_ff;
         s5_mag_ff   <= s4_mag_ff;
         s5_pos_ff   <= pos_in;
         s5_degen_ff <= (mag_or == '0);

         s6_side_ff.degen <= s5_degen_ff;
         s6_side_ff.neg   <= s5_neg_ff;
         s6_side_ff.mag   <= norm_in;

         s7_side_ff <= s6_side_ff;
         for (int k = 0; k < 3; k++) begin
            s7_sq_ff[k] <= s6_side_ff.mag[k] * s6_side_ff.mag[k];
         end

         s8_side_ff <= s7_side_ff;
         s8_sum_ff  <= tun_pkg::SUM_W'(s7_sq_ff[0]) + tun_pkg::SUM_W'(s7_sq_ff[1])
                     + tun_pkg::SUM_W'(s7_sq_ff[2]);

         s9_len_ff        <= sq_root;
         s9_num_ff        <= num_in;
         s9_side_ff.degen <= sq_side.degen;
         s9_side_ff.neg   <= sq_side.neg;

         out_n_ff     <= n_in;
         out_degen_ff <= dv_side.degen;
      end
   end

   tun_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_vld_ff),
      .in_sum    (s8_sum_ff),
      .in_side   (s8_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   tun_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s9_vld_ff),
      .in_divisor (s9_len_ff),
      .in_num     (s9_num_ff),
      .in_side    (s9_side_ff),
      .out_valid  (dv_vld),
      .out_quot   (dv_quot),
      .out_side   (dv_side)
   );

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.normal_x   = out_n_ff[0];
   assign rsp_ch.normal_y   = out_n_ff[1];
   assign rsp_ch.normal_z   = out_n_ff[2];
   assign rsp_ch.degenerate = out_degen_ff;

endmodule
